/* rtl/aopt_pkg.sv */
// Shared types and constants for the arc odometry pose tracker.
// Holds the datapath operation codes, the multiplier operand selects, the
// controller-to-datapath structs and the fixed-point constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aopt_pkg;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_HEAD,
    OP_DIV_WHEEL,
    OP_DIV_STEP,
    OP_END_DF,
    OP_END_DS,
    OP_ROT1_INIT,
    OP_DIV_MOD,
    OP_END_MOD,
    OP_RED1,
    OP_RED2,
    OP_CORDIC,
    OP_T1,
    OP_T2,
    OP_FIX,
    OP_XG,
    OP_YG,
    OP_DIV_C,
    OP_END_C,
    OP_LX1,
    OP_LX2,
    OP_LY,
    OP_STRAIGHT,
    OP_ROT2_INIT,
    OP_COMMIT,
    OP_WHEEL_Q,
    OP_WHEEL_R
  } op_e;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MS_HEAD,
    MS_FWD,
    MS_SIDE,
    MS_DSC,
    MS_DFC,
    MS_OFF,
    MS_YZ,
    MS_XZ,
    MS_XG,
    MS_YG,
    MS_WREC
  } msel_e;

  typedef struct packed {
    op_e         op;
    msel_e       msel;
    logic [4:0]  idx;
  } dp_cmd_t;

  typedef struct packed {
    logic dt_zero;
  } dp_stat_t;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_CIRC       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_X    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_Y    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_START_HEAD = 3'd4;

  localparam logic [23:0] CIRC_RESET = 24'd566231;

  // fixed-point constants, angles in q30 radians
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [33:0] HEAD_K20    = 34'sd599690565;
  localparam logic [63:0]        WHEEL_HALF  = 64'd180;
  localparam logic [63:0]        HEAD_ROUND  = 64'd524288;

  // reciprocals of 360: floor(2^41 / 360) for the coarse quotient,
  // ceil(2^33 / 360) exact on the small residue
  localparam logic signed [33:0] WHEEL_REC   = 34'sd6108397932;
  localparam logic [24:0]        WHEEL_REC2  = 25'd23860930;

  // arctangent table in q30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

`default_nettype wire

/* rtl/aopt_datapath.sv */
// Datapath of the pose tracker: config and pose registers, one shared
// multiplier, a restoring divider and a cordic rotator, all driven by command.
// Depends on aopt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aopt_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  aopt_pkg::dp_cmd_t                    cmd_i,
  output aopt_pkg::dp_stat_t                   stat_o,
  input  logic                                 cfg_we_i,
  input  logic [aopt_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  input  logic signed [31:0]                   forward_wheel_deg_i,
  input  logic signed [31:0]                   side_wheel_deg_i,
  input  logic signed [31:0]                   imu_a_deg_i,
  input  logic                                 imu_a_valid_i,
  input  logic signed [31:0]                   imu_b_deg_i,
  input  logic                                 imu_b_valid_i,
  output logic signed [31:0]                   pos_x_o,
  output logic signed [31:0]                   pos_y_o,
  output logic signed [31:0]                   heading_o
);
  import aopt_pkg::*;

  // configuration and pose state
  logic [23:0]        circ_q;
  logic signed [23:0] off_q;
  logic [27:0]        start_head_q;
  logic [31:0]        last_fwd_q, last_side_q, last_head_q;
  logic [31:0]        acc_x_q, acc_y_q, acc_head_q;

  // per-word working registers
  logic [31:0]        fwd_q, side_q, reading_q;
  logic signed [32:0] sum_q;
  logic signed [31:0] dt_q;
  logic signed [63:0] df_q, ds_q, lx_q, ly_q, x_q, y_q, t1_q, t2_q, ang_q;
  logic signed [33:0] c_q;
  logic signed [34:0] z_q;
  logic               rneg_q;
  logic signed [99:0] prod_q;
  logic [63:0]        dq_q, dr_q, dd_q;
  logic               dneg_q;

  // helpers
  logic [31:0]        fwd_diff, side_diff;
  logic signed [63:0] mul_v;
  logic signed [33:0] mul_k;
  logic signed [32:0] mul_a;
  logic signed [66:0] mul_p;
  logic signed [63:0] q30, p64, head_t, y_sh22, sy8, dt_ext, rot2_ang;
  logic [63:0]        wheel_mag, ang_mag, sy8_mag, dt_mag, div_q_s, div_r_s;
  logic [64:0]        div_sh;
  logic [65:0]        div_sub;
  logic               div_ge;
  logic signed [34:0] z_red1, atan_v;
  logic signed [63:0] x_shr, y_shr;
  logic [63:0]        dr_x360, wheel_q, wheel_s;
  logic [48:0]        rem_prod;

  assign fwd_diff  = fwd_q - last_fwd_q;
  assign side_diff = side_q - last_side_q;
  assign y_sh22    = y_q >>> 22;
  assign dt_ext    = {{32{dt_q[31]}}, dt_q};

  // multiplier operand select
  always_comb begin
    case (cmd_i.msel)
      MS_HEAD: begin
        mul_v = {{31{sum_q[32]}}, sum_q};
        mul_k = HEAD_K20;
      end
      MS_FWD: begin
        mul_v = {{32{fwd_diff[31]}}, fwd_diff};
        mul_k = {10'b0, circ_q};
      end
      MS_SIDE: begin
        mul_v = {{32{side_diff[31]}}, side_diff};
        mul_k = {10'b0, circ_q};
      end
      MS_DSC: begin
        mul_v = ds_q;
        mul_k = c_q;
      end
      MS_DFC: begin
        mul_v = df_q;
        mul_k = c_q;
      end
      MS_OFF: begin
        mul_v = {{40{off_q[23]}}, off_q};
        mul_k = y_sh22[33:0];
      end
      MS_YZ: begin
        mul_v = y_q;
        mul_k = z_q[33:0];
      end
      MS_XZ: begin
        mul_v = x_q;
        mul_k = z_q[33:0];
      end
      MS_XG: begin
        mul_v = x_q;
        mul_k = GAIN_Q30;
      end
      MS_YG: begin
        mul_v = y_q;
        mul_k = GAIN_Q30;
      end
      MS_WREC: begin
        mul_v = $signed(dq_q);
        mul_k = WHEEL_REC;
      end
      default: begin
        mul_v = '0;
        mul_k = '0;
      end
    endcase
  end

  // shared multiplier: low 32 bits of v, then the signed upper half
  assign mul_a = (cmd_i.op == OP_MUL_HI) ? {mul_v[63], mul_v[63:32]} : {1'b0, mul_v[31:0]};
  assign mul_p = mul_a * mul_k;
  assign q30   = prod_q[93:30];
  assign p64   = prod_q[63:0];

  // heading reading rounding
  assign head_t = 64'sd0 - p64 + $signed(HEAD_ROUND);

  // divider operand magnitudes
  assign wheel_mag = (p64[63] ? 64'(-p64) : 64'(p64)) + WHEEL_HALF;
  assign ang_mag   = ang_q[63] ? 64'(-ang_q) : 64'(ang_q);
  assign sy8       = y_q <<< 3;
  assign sy8_mag   = sy8[63] ? 64'(-sy8) : 64'(sy8);
  assign dt_mag    = dt_ext[63] ? 64'(-dt_ext) : 64'(dt_ext);

  // restoring divider step
  assign div_sh  = {dr_q, dq_q[63]};
  assign div_sub = {1'b0, div_sh} - {2'b0, dd_q};
  assign div_ge  = !div_sub[65];
  assign div_q_s = dneg_q ? (64'd0 - dq_q) : dq_q;
  assign div_r_s = dneg_q ? (64'd0 - dr_q) : dr_q;

  // wheel divide by 360: coarse quotient in dr, residue in dd, exact fine step
  assign dr_x360  = (dr_q << 8) + (dr_q << 6) + (dr_q << 5) + (dr_q << 3);
  assign rem_prod = dd_q[23:0] * WHEEL_REC2;
  assign wheel_q  = dr_q + {48'b0, rem_prod[48:33]};
  assign wheel_s  = dneg_q ? (64'd0 - wheel_q) : wheel_q;

  // angle range reduction to +-pi
  always_comb begin
    if (z_q > PI_Q30) begin
      z_red1 = z_q - TWO_PI_Q30;
    end else if (z_q < -PI_Q30) begin
      z_red1 = z_q + TWO_PI_Q30;
    end else begin
      z_red1 = z_q;
    end
  end

  // cordic shifts
  assign x_shr  = x_q >>> cmd_i.idx;
  assign y_shr  = y_q >>> cmd_i.idx;
  assign atan_v = $signed({3'b000, ATAN_Q30[cmd_i.idx]});

  assign rot2_ang = 64'sd0 - ({{26{acc_head_q[31]}}, acc_head_q, 6'b0} + (dt_ext <<< 5));

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        fwd_q  <= forward_wheel_deg_i;
        side_q <= side_wheel_deg_i;
        sum_q  <= (imu_a_valid_i ? 33'(imu_a_deg_i) : 33'sd0)
                + (imu_b_valid_i ? 33'(imu_b_deg_i) : 33'sd0);
      end
      OP_MUL_LO: prod_q <= {{33{mul_p[66]}}, mul_p};
      OP_MUL_HI: prod_q <= prod_q + {mul_p[66], mul_p, 32'b0};
      OP_HEAD: begin
        reading_q <= head_t[51:20];
        dt_q      <= head_t[51:20] - last_head_q;
      end
      OP_DIV_WHEEL: begin
        dq_q   <= wheel_mag;
        dneg_q <= p64[63];
      end
      OP_WHEEL_Q: dr_q <= q30 >>> 11;
      OP_WHEEL_R: dd_q <= dq_q - dr_x360;
      OP_DIV_MOD: begin
        // quotient below 64, so six steps from a pre-shifted dividend
        dq_q   <= {ang_mag[5:0], 58'b0};
        dr_q   <= {6'b0, ang_mag[63:6]};
        dd_q   <= 64'(TWO_PI_Q30);
        dneg_q <= ang_q[63];
      end
      OP_DIV_C: begin
        dq_q   <= sy8_mag;
        dr_q   <= '0;
        dd_q   <= dt_mag;
        dneg_q <= y_q[63] ^ dt_q[31];
      end
      OP_DIV_STEP: begin
        dr_q <= div_ge ? div_sub[63:0] : div_sh[63:0];
        dq_q <= {dq_q[62:0], div_ge};
      end
      OP_END_DF: df_q <= wheel_s;
      OP_END_DS: ds_q <= wheel_s;
      OP_END_C:  c_q  <= div_q_s[33:0];
      OP_ROT1_INIT: begin
        x_q   <= 64'sd1 <<< 52;
        y_q   <= '0;
        ang_q <= dt_ext <<< 5;
      end
      OP_ROT2_INIT: begin
        x_q   <= lx_q;
        y_q   <= ly_q;
        ang_q <= rot2_ang;
      end
      OP_END_MOD: z_q <= div_r_s[34:0];
      OP_RED1:    z_q <= z_red1;
      OP_RED2: begin
        if (z_q > HALF_PI_Q30) begin
          z_q    <= z_q - PI_Q30;
          rneg_q <= 1'b1;
        end else if (z_q < -HALF_PI_Q30) begin
          z_q    <= z_q + PI_Q30;
          rneg_q <= 1'b1;
        end else begin
          rneg_q <= 1'b0;
        end
      end
      OP_CORDIC: begin
        if (!z_q[34]) begin
          x_q <= x_q - y_shr;
          y_q <= y_q + x_shr;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + y_shr;
          y_q <= y_q - x_shr;
          z_q <= z_q + atan_v;
        end
      end
      OP_T1: t1_q <= q30;
      OP_T2: t2_q <= q30;
      OP_FIX: begin
        x_q <= x_q - t1_q;
        y_q <= y_q + t2_q;
      end
      OP_XG: x_q <= q30;
      OP_YG: begin
        x_q <= rneg_q ? -x_q : x_q;
        y_q <= rneg_q ? -q30 : q30;
      end
      OP_LX1: lx_q <= q30;
      OP_LX2: lx_q <= lx_q + (q30 <<< 1);
      OP_LY:  ly_q <= q30;
      OP_STRAIGHT: begin
        lx_q <= ds_q;
        ly_q <= df_q;
      end
      default: ;
    endcase
  end

  // config and pose registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q       <= CIRC_RESET;
      off_q        <= '0;
      start_head_q <= '0;
      last_fwd_q   <= '0;
      last_side_q  <= '0;
      last_head_q  <= '0;
      acc_x_q      <= '0;
      acc_y_q      <= '0;
      acc_head_q   <= '0;
    end else begin
      if (cmd_i.op == OP_COMMIT) begin
        acc_x_q     <= acc_x_q + y_q[31:0];
        acc_y_q     <= acc_y_q + x_q[31:0];
        last_fwd_q  <= fwd_q;
        last_side_q <= side_q;
        last_head_q <= reading_q;
        acc_head_q  <= reading_q + {{4{start_head_q[27]}}, start_head_q};
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_CIRC:   circ_q <= cfg_data_i[23:0];
          CFG_OFFSET: off_q  <= cfg_data_i[23:0];
          CFG_START_X: acc_x_q <= cfg_data_i;
          CFG_START_Y: acc_y_q <= cfg_data_i;
          CFG_START_HEAD: begin
            start_head_q <= cfg_data_i[27:0];
            acc_head_q   <= {{4{cfg_data_i[27]}}, cfg_data_i[27:0]};
          end
          default: ;
        endcase
      end
    end
  end

  assign stat_o.dt_zero = (dt_q == 32'sd0);
  assign pos_x_o   = acc_x_q;
  assign pos_y_o   = acc_y_q;
  assign heading_o = acc_head_q;

endmodule

`default_nettype wire

/* rtl/aopt_ctrl.sv */
// Sequencer of the pose tracker: steps the datapath through heading, wheel
// deltas, arc factor and pose rotation, and owns the word handshakes.
// Depends on aopt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aopt_ctrl #(
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aopt_pkg::dp_cmd_t   cmd_o,
  input  aopt_pkg::dp_stat_t  stat_i
);
  import aopt_pkg::*;

  localparam logic [5:0] ST_IDLE     = 6'd0;
  localparam logic [5:0] ST_MUL_LO   = 6'd1;
  localparam logic [5:0] ST_MUL_HI   = 6'd2;
  localparam logic [5:0] ST_DIV      = 6'd3;
  localparam logic [5:0] ST_HEAD     = 6'd4;
  localparam logic [5:0] ST_FWD_DIV  = 6'd5;
  localparam logic [5:0] ST_FWD_END  = 6'd6;
  localparam logic [5:0] ST_SIDE_DIV = 6'd7;
  localparam logic [5:0] ST_SIDE_END = 6'd8;
  localparam logic [5:0] ST_ROT1     = 6'd9;
  localparam logic [5:0] ST_MOD_DIV  = 6'd10;
  localparam logic [5:0] ST_MOD_END  = 6'd11;
  localparam logic [5:0] ST_RED1     = 6'd12;
  localparam logic [5:0] ST_RED2     = 6'd13;
  localparam logic [5:0] ST_CORD     = 6'd14;
  localparam logic [5:0] ST_T1       = 6'd15;
  localparam logic [5:0] ST_T2       = 6'd16;
  localparam logic [5:0] ST_FIX      = 6'd17;
  localparam logic [5:0] ST_XG       = 6'd18;
  localparam logic [5:0] ST_YG       = 6'd19;
  localparam logic [5:0] ST_C_DIV    = 6'd20;
  localparam logic [5:0] ST_C_END    = 6'd21;
  localparam logic [5:0] ST_LX1      = 6'd22;
  localparam logic [5:0] ST_LX2      = 6'd23;
  localparam logic [5:0] ST_LY       = 6'd24;
  localparam logic [5:0] ST_STRAIGHT = 6'd25;
  localparam logic [5:0] ST_ROT2     = 6'd26;
  localparam logic [5:0] ST_COMMIT   = 6'd27;
  localparam logic [5:0] ST_FWD_Q    = 6'd28;
  localparam logic [5:0] ST_SIDE_Q   = 6'd29;
  localparam logic [5:0] ST_WHEEL_R  = 6'd30;

  localparam logic [5:0] DivLast  = 6'd63;
  localparam logic [5:0] ModFirst = 6'd58;
  localparam logic [5:0] CordLast = 6'(CORDIC_ITERATIONS - 1);

  logic [5:0] state_q, state_d, ret_q, ret_d, cnt_q, cnt_d;
  msel_e      msel_q, msel_d;
  logic       pass_q, pass_d, out_valid_q, out_valid_d;
  op_e        op;

  // sequencing
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    cnt_d       = cnt_q;
    msel_d      = msel_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && out_stall_i;
    op          = OP_NOP;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          msel_d  = MS_HEAD;
          ret_d   = ST_HEAD;
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        op      = OP_MUL_LO;
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        op      = OP_MUL_HI;
        state_d = ret_q;
      end
      ST_DIV: begin
        op = OP_DIV_STEP;
        if (cnt_q == DivLast) begin
          cnt_d   = '0;
          state_d = ret_q;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_HEAD: begin
        op      = OP_HEAD;
        msel_d  = MS_FWD;
        ret_d   = ST_FWD_DIV;
        state_d = ST_MUL_LO;
      end
      ST_FWD_DIV: begin
        op      = OP_DIV_WHEEL;
        msel_d  = MS_WREC;
        ret_d   = ST_FWD_Q;
        state_d = ST_MUL_LO;
      end
      ST_FWD_Q: begin
        op      = OP_WHEEL_Q;
        ret_d   = ST_FWD_END;
        state_d = ST_WHEEL_R;
      end
      ST_WHEEL_R: begin
        op      = OP_WHEEL_R;
        state_d = ret_q;
      end
      ST_FWD_END: begin
        op      = OP_END_DF;
        msel_d  = MS_SIDE;
        ret_d   = ST_SIDE_DIV;
        state_d = ST_MUL_LO;
      end
      ST_SIDE_DIV: begin
        op      = OP_DIV_WHEEL;
        msel_d  = MS_WREC;
        ret_d   = ST_SIDE_Q;
        state_d = ST_MUL_LO;
      end
      ST_SIDE_Q: begin
        op      = OP_WHEEL_Q;
        ret_d   = ST_SIDE_END;
        state_d = ST_WHEEL_R;
      end
      ST_SIDE_END: begin
        op      = OP_END_DS;
        state_d = stat_i.dt_zero ? ST_STRAIGHT : ST_ROT1;
      end
      ST_ROT1: begin
        op      = OP_ROT1_INIT;
        pass_d  = 1'b0;
        state_d = ST_MOD_DIV;
      end
      ST_MOD_DIV: begin
        op      = OP_DIV_MOD;
        cnt_d   = ModFirst;
        ret_d   = ST_MOD_END;
        state_d = ST_DIV;
      end
      ST_MOD_END: begin
        op      = OP_END_MOD;
        state_d = ST_RED1;
      end
      ST_RED1: begin
        op      = OP_RED1;
        state_d = ST_RED2;
      end
      ST_RED2: begin
        op      = OP_RED2;
        cnt_d   = '0;
        state_d = ST_CORD;
      end
      ST_CORD: begin
        op = OP_CORDIC;
        if (cnt_q == CordLast) begin
          cnt_d   = '0;
          msel_d  = MS_YZ;
          ret_d   = ST_T1;
          state_d = ST_MUL_LO;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_T1: begin
        op      = OP_T1;
        msel_d  = MS_XZ;
        ret_d   = ST_T2;
        state_d = ST_MUL_LO;
      end
      ST_T2: begin
        op      = OP_T2;
        state_d = ST_FIX;
      end
      ST_FIX: begin
        op      = OP_FIX;
        msel_d  = MS_XG;
        ret_d   = ST_XG;
        state_d = ST_MUL_LO;
      end
      ST_XG: begin
        op      = OP_XG;
        msel_d  = MS_YG;
        ret_d   = ST_YG;
        state_d = ST_MUL_LO;
      end
      ST_YG: begin
        op      = OP_YG;
        state_d = pass_q ? ST_COMMIT : ST_C_DIV;
      end
      ST_C_DIV: begin
        op      = OP_DIV_C;
        ret_d   = ST_C_END;
        state_d = ST_DIV;
      end
      ST_C_END: begin
        op      = OP_END_C;
        msel_d  = MS_DSC;
        ret_d   = ST_LX1;
        state_d = ST_MUL_LO;
      end
      ST_LX1: begin
        op      = OP_LX1;
        msel_d  = MS_OFF;
        ret_d   = ST_LX2;
        state_d = ST_MUL_LO;
      end
      ST_LX2: begin
        op      = OP_LX2;
        msel_d  = MS_DFC;
        ret_d   = ST_LY;
        state_d = ST_MUL_LO;
      end
      ST_LY: begin
        op      = OP_LY;
        state_d = ST_ROT2;
      end
      ST_STRAIGHT: begin
        op      = OP_STRAIGHT;
        state_d = ST_ROT2;
      end
      ST_ROT2: begin
        op      = OP_ROT2_INIT;
        pass_d  = 1'b1;
        state_d = ST_MOD_DIV;
      end
      ST_COMMIT: begin
        // wait until the previous pose word has left
        if (!out_valid_q || !out_stall_i) begin
          op          = OP_COMMIT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      cnt_q       <= '0;
      msel_q      <= MS_HEAD;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cnt_q       <= cnt_d;
      msel_q      <= msel_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.op   = op;
  assign cmd_o.msel = msel_q;
  assign cmd_o.idx  = cnt_q[4:0];
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/arc_odometry_pose_tracker.sv */
// Tracking-wheel arc odometry: one pose word per input word, computed by a
// sequencer over a shared multiplier, a 64-step divider and a cordic rotator.
// A word takes one cordic pass when the heading is unchanged, else a first
// pass, the arc-factor divide and a second pass, plus any wait for the previous
// pose word to leave; one word at a time, input stalled until the commit.
// Reset: config to defaults, pose and stored readings to zero, no word pending.
`timescale 1ns / 1ps
`default_nettype none

module arc_odometry_pose_tracker #(
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            forward_wheel_deg_i,
  input  logic signed [31:0]            side_wheel_deg_i,
  input  logic signed [31:0]            imu_a_deg_i,
  input  logic                          imu_a_valid_i,
  input  logic signed [31:0]            imu_b_deg_i,
  input  logic                          imu_b_valid_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic signed [31:0]            heading_o,
  input  logic                          cfg_we_i,
  input  logic [aopt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import aopt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  aopt_ctrl #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // arithmetic and state
  aopt_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .forward_wheel_deg_i (forward_wheel_deg_i),
    .side_wheel_deg_i    (side_wheel_deg_i),
    .imu_a_deg_i         (imu_a_deg_i),
    .imu_a_valid_i       (imu_a_valid_i),
    .imu_b_deg_i         (imu_b_deg_i),
    .imu_b_valid_i       (imu_b_valid_i),
    .pos_x_o             (pos_x_o),
    .pos_y_o             (pos_y_o),
    .heading_o           (heading_o)
  );

endmodule

`default_nettype wire
